// ----- hdl/knt_pkg.sv -----
package knt_pkg;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_KEY_ZERO  = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [14:0] kind_key;
      logic [15:0] note_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [5:0]  slot;
      logic [15:0] handle_out;
      logic [6:0]  count_out;
   } rsp_type;

   typedef struct packed {
      logic [14:0] key;
      logic [15:0] handle;
   } entry_type;

endpackage

// ----- hdl/knt_mem.sv -----
module knt_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  knt_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output knt_pkg::entry_type  rd_data
);
   import knt_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/keyed_note_table_top.sv -----
// Packed key/handle table in one memory with a registered read port and a
// separate write port. A request walks the used entries one per cycle in
// slot order; a remove of the entry at slot p then moves the later entries
// down one per cycle. A remove stops its search at p and only walks the
// entries above it, and the search and the compaction share the single
// read port. The next request is taken once the result is in the output
// register.
module keyed_note_table_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  knt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output knt_pkg::rsp_type rsp_data
);
   import knt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_ACT,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [15:0]      hout_ff, hout_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   logic             req_beat;
   logic             is_remove;
   logic             is_add;
   logic             issue;
   logic             hit;

   knt_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_remove = (req_ff.mode == MODE_REMOVE) ||
                      ((req_ff.mode == MODE_ADD) && (req_ff.note_handle == 16'd0));
   assign is_add    = (req_ff.mode == MODE_ADD) && (req_ff.note_handle != 16'd0);
   assign issue     = (scan_ff < count_ff);
   assign hit       = rd_pend_ff && (mem_rd_data.key == req_ff.kind_key);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      hout_in      = hout_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_ff[IDX_W-1:0];
      mem_wr_data  = '{key: req_ff.kind_key, handle: req_ff.note_handle};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = scan_ff[IDX_W-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               req_in     = req_data;
               scan_in    = '0;
               rd_pend_in = 1'b0;
               found_in   = 1'b0;
               pos_in     = '0;
               hout_in    = '0;
               res_in     = '0;
               if ((req_data.mode == MODE_ADD) && (req_data.kind_key == 15'd0)) begin
                  res_in.status = ST_KEY_ZERO;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            mem_rd_en  = issue;
            rd_pend_in = issue;
            rd_idx_in  = scan_ff;
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               found_in = 1'b1;
               pos_in   = rd_idx_ff;
               hout_in  = mem_rd_data.handle;
               state_in = S_ACT;
            end else if (!issue && !rd_pend_ff) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            res_in.found = found_ff;
            state_in     = S_DONE;
            if (is_remove) begin
               if (found_ff) begin
                  res_in.slot = 6'(pos_ff);
                  scan_in     = pos_ff + 1'b1;
                  rd_pend_in  = 1'b0;
                  state_in    = S_SHIFT;
               end else begin
                  res_in.status = ST_NOT_FOUND;
               end
            end else if (is_add) begin
               if (found_ff) begin
                  mem_wr_en   = 1'b1;
                  res_in.slot = 6'(pos_ff);
               end else if (count_ff >= FULL_COUNT) begin
                  res_in.status = ST_FULL;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[IDX_W-1:0];
                  res_in.slot = 6'(count_ff);
                  count_in    = count_ff + 1'b1;
               end
            end else begin
               if (found_ff) begin
                  res_in.slot       = 6'(pos_ff);
                  res_in.handle_out = hout_ff;
               end else begin
                  res_in.status = ST_NOT_FOUND;
               end
            end
         end
         S_SHIFT: begin
            mem_rd_en  = issue;
            rd_pend_in = issue;
            rd_idx_in  = scan_ff;
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = IDX_W'(rd_idx_ff - 1'b1);
               mem_wr_data = mem_rd_data;
            end
            if (!issue && !rd_pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in           = res_ff;
               rsp_in.count_out = 7'(count_ff);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      scan_ff   <= scan_in;
      rd_idx_ff <= rd_idx_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      hout_ff   <= hout_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above table depth");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_ACT) || (state_ff == S_SHIFT))
      else $error("memory write outside update states");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_FULL)) |-> rsp_ff.count_out == 7'(TABLE_DEPTH))
      else $error("table full reported below depth");

   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_KEY_ZERO)) |-> !rsp_ff.found && rsp_ff.slot == 6'd0)
      else $error("rejected key reported as found");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
   import knt_pkg::*;

   localparam int         TABLE_DEPTH  = 64;
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         POOL_SIZE    = 80;
   localparam int         IDLE_PCT     = 28;
   localparam int         HOLD_AT_BEAT = 120;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         QUIET_LO     = 250;
   localparam int         QUIET_HI     = 330;
   localparam int         DRAIN_CYCLES = 200;
   localparam int         CYCLE_LIMIT  = 400000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   keyed_note_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the table
   logic [14:0]  note_keys    [TABLE_DEPTH];
   logic [15:0]  note_handles [TABLE_DEPTH];
   int           note_count = 0;
   int           peak_count = 0;

   req_type      request_queue [$];
   rsp_type      pending_results [$];
   logic [14:0]  key_pool [POOL_SIZE];

   int           item_total  = 0;
   int           beats_in    = 0;
   int           beats_out   = 0;
   int           errors      = 0;
   int           cycle_count = 0;
   int           hold_left   = 0;
   logic         hold_done   = 1'b0;
   int           status_seen [4] = '{0, 0, 0, 0};
   rsp_type      want;

   function automatic rsp_type apply_request(input req_type rq);
      rsp_type    rs;
      int         pos;
      int         i;
      logic [1:0] op;
      rs  = '0;
      op  = rq.mode;
      pos = -1;
      if (op == MODE_ADD && rq.kind_key == 15'd0) begin
         rs.status = ST_KEY_ZERO;
      end else begin
         i = 0;
         while (i < note_count && pos < 0) begin
            if (note_keys[i] == rq.kind_key) pos = i;
            i++;
         end
         rs.found = (pos >= 0);
         // empty note on add means remove
         if (op == MODE_ADD && rq.note_handle == 16'd0) op = MODE_REMOVE;
         if (op == MODE_REMOVE) begin
            if (pos >= 0) begin
               rs.slot = pos[5:0];
               for (i = pos; i < note_count - 1; i++) begin
                  note_keys[i]    = note_keys[i + 1];
                  note_handles[i] = note_handles[i + 1];
               end
               note_count--;
            end else begin
               rs.status = ST_NOT_FOUND;
            end
         end else if (op == MODE_ADD) begin
            if (pos >= 0) begin
               note_handles[pos] = rq.note_handle;
               rs.slot           = pos[5:0];
            end else if (note_count >= TABLE_DEPTH) begin
               rs.status = ST_FULL;
            end else begin
               note_keys[note_count]    = rq.kind_key;
               note_handles[note_count] = rq.note_handle;
               rs.slot                  = note_count[5:0];
               note_count++;
            end
         end else begin
            if (pos >= 0) begin
               rs.slot       = pos[5:0];
               rs.handle_out = note_handles[pos];
            end else begin
               rs.status = ST_NOT_FOUND;
            end
         end
      end
      if (note_count > peak_count) peak_count = note_count;
      rs.count_out = note_count[6:0];
      return rs;
   endfunction

   task automatic push_req(input logic [1:0] mode, input logic [14:0] key,
                           input logic [15:0] handle);
      req_type rq;
      rq.mode        = mode;
      rq.kind_key    = key;
      rq.note_handle = handle;
      request_queue.push_back(rq);
   endtask

   function automatic logic [15:0] some_handle();
      if ($urandom_range(0, 99) < 5) return 16'd0;
      return 16'($urandom_range(1, 65535));
   endfunction

   // pct_add/pct_look/pct_rem are cumulative thresholds; the rest is noise
   task automatic push_random(input int pct_add, input int pct_look, input int pct_rem);
      int          r;
      logic [14:0] key;
      r   = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < pct_add)       push_req(MODE_ADD, key, some_handle());
      else if (r < pct_look) push_req(($urandom_range(0, 9) == 0) ? MODE_SPARE : MODE_LOOKUP,
                                      key, 16'($urandom));
      else if (r < pct_rem)  push_req(MODE_REMOVE, key, 16'($urandom));
      else push_req(2'($urandom_range(0, 3)),
                    ($urandom_range(0, 4) == 0) ? 15'd0 : 15'($urandom_range(0, 32767)),
                    ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            pending_results.push_back(apply_request(req_data));
            beats_in <= beats_in + 1;
         end
         if (request_queue.size() != 0 &&
             ((beats_in >= QUIET_LO && beats_in < QUIET_HI) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data  <= request_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall, with one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && beats_out == HOLD_AT_BEAT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !(beats_out >= QUIET_LO && beats_out < QUIET_HI) &&
                      ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     beats_out, name, expv, actv);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out <= beats_out + 1;
         status_seen[rsp_data.status]++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("result %0d arrived with nothing expected", beats_out);
         end else begin
            want = pending_results.pop_front();
            check_field("status",     want.status,     rsp_data.status);
            check_field("found",      want.found,      rsp_data.found);
            check_field("slot",       want.slot,       rsp_data.slot);
            check_field("handle_out", want.handle_out, rsp_data.handle_out);
            check_field("count_out",  want.count_out,  rsp_data.count_out);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results", cycle_count, beats_out,
                  item_total);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = {i[6:0], 8'($urandom_range(1, 255))};

      // directed: corner keys, handles and several odd cases, from an empty table
      push_req(MODE_LOOKUP, 15'd0,      16'd0);
      push_req(MODE_REMOVE, 15'd5,      16'd9);
      push_req(MODE_ADD,    15'd0,      16'd1234);
      push_req(MODE_ADD,    15'd0,      16'd0);
      push_req(MODE_ADD,    15'h7FFF,   16'hFFFF);
      push_req(MODE_ADD,    15'd1,      16'd1);
      push_req(MODE_LOOKUP, 15'h7FFF,   16'd0);
      push_req(MODE_SPARE,  15'd1,      16'hFFFF);
      push_req(MODE_ADD,    15'd1,      16'h8000);
      push_req(MODE_LOOKUP, 15'd1,      16'd0);
      push_req(MODE_ADD,    15'h7FFF,   16'd0);
      push_req(MODE_LOOKUP, 15'h7FFF,   16'd0);
      push_req(MODE_ADD,    15'h2AAA,   16'h5555);
      push_req(MODE_ADD,    15'h5555,   16'hAAAA);
      push_req(MODE_ADD,    15'd3,      16'd7);
      push_req(MODE_REMOVE, 15'h2AAA,   16'd0);
      push_req(MODE_LOOKUP, 15'd3,      16'd0);
      push_req(MODE_REMOVE, 15'd0,      16'd0);
      push_req(MODE_SPARE,  15'd0,      16'd0);
      push_req(MODE_ADD,    15'h5555,   16'd0);
      push_req(MODE_REMOVE, 15'd1,      16'd0);
      push_req(MODE_REMOVE, 15'd3,      16'd0);
      push_req(MODE_LOOKUP, 15'd1,      16'd0);

      // fill past full, drain, then a mixed tail
      repeat (200) push_random(78, 88, 96);
      repeat (100) push_random(20, 40, 90);
      repeat (80)  push_random(30, 60, 85);
      item_total = request_queue.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (beats_out < item_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0d expected results never arrived", pending_results.size());
      end

      $display("%0d requests in %0d cycles: %0d done, %0d misses, %0d full, %0d zero-key",
               item_total, cycle_count, status_seen[ST_DONE], status_seen[ST_NOT_FOUND],
               status_seen[ST_FULL], status_seen[ST_KEY_ZERO]);
      $display("table peaked at %0d of %0d entries, %0d field mismatches",
               peak_count, TABLE_DEPTH, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
